@@ src/aescbc_pkg.sv @@
`default_nettype none

package aescbc_pkg;

   localparam int NUM_ROUNDS  = 10;
   localparam int BLOCK_BYTES = 16;

   typedef logic [255:0][7:0]           sbox_table_type;
   typedef logic [NUM_ROUNDS:0][127:0]  round_keys_type;

   // one block in flight through the round pipeline
   typedef struct packed {
      logic [127:0] state;
      logic [127:0] chain;
      logic         last;
      logic         empty;
   } stage_type;

   // key schedule status seen by the top level
   typedef struct packed {
      logic busy;
   } key_status_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
   endfunction

   // used at elaboration only to build the tables
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = xtime(x);
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      r = 8'h01;
      for (int i = 0; i < 254; i++) r = gf_mul(r, x);
      return r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic sbox_table_type build_table(input logic inverse);
      sbox_table_type t;
      logic [7:0] v;
      logic [7:0] b;
      for (int i = 0; i < 256; i++) begin
         v = i[7:0];
         if (inverse) begin
            b = rotl8(v, 1) ^ rotl8(v, 3) ^ rotl8(v, 6) ^ 8'h05;
            t[i] = gf_inv(b);
         end else begin
            b = gf_inv(v);
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
         end
      end
      return t;
   endfunction

   localparam sbox_table_type SBOX     = build_table(1'b0);
   localparam sbox_table_type INV_SBOX = build_table(1'b1);

   // one step of the key expansion
   function automatic logic [127:0] next_round_key(input logic [127:0] prev,
                                                   input logic [7:0] rcon);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = {SBOX[prev[23:16]] ^ rcon, SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
      w0 = prev[127:96] ^ t;
      w1 = prev[95:64] ^ w0;
      w2 = prev[63:32] ^ w1;
      w3 = prev[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // InvShiftRows and InvSubBytes; byte 0 sits in bits 127:120
   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = 4 * ((c - r + 4) & 3) + r;
            t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            a[r]   = s[127 - 8 * (4 * c + r) -: 8];
            x2[r]  = xtime(a[r]);
            x4[r]  = xtime(x2[r]);
            x8[r]  = xtime(x4[r]);
            m9[r]  = x8[r] ^ a[r];
            m11[r] = x8[r] ^ x2[r] ^ a[r];
            m13[r] = x8[r] ^ x4[r] ^ a[r];
            m14[r] = x8[r] ^ x4[r] ^ x2[r];
         end
         t[127 - 8 * (4 * c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
         t[127 - 8 * (4 * c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
         t[127 - 8 * (4 * c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
         t[127 - 8 * (4 * c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ src/aescbc_if.sv @@
`default_nettype none

interface aescbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        is_iv;
   logic        end_of_message;

   modport source (output valid, block_high, block_low, is_iv, end_of_message,
                   input ready);
   modport sink (input valid, block_high, block_low, is_iv, end_of_message,
                 output ready);
endinterface

interface aescbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_high;
   logic [63:0] plain_low;
   logic        final_block;
   logic        padding_valid;

   modport source (output valid, plain_high, plain_low, final_block, padding_valid,
                   input ready);
   modport sink (input valid, plain_high, plain_low, final_block, padding_valid,
                 output ready);
endinterface

`default_nettype wire

@@ src/aescbc_key_sched.sv @@
`default_nettype none

module aescbc_key_sched
   import aescbc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_we,
   input  wire logic           csr_index,
   input  wire logic [63:0]    csr_wdata,
   output round_keys_type      round_key,
   output key_status_type      status
);

   localparam logic [3:0] LAST_STEP = 4'(NUM_ROUNDS);
   localparam logic       IDX_KEY_HIGH = 1'b0;

   logic [63:0]  key_high_ff;
   logic [63:0]  key_low_ff;
   logic [127:0] cur_ff;
   logic [127:0] cur_in;
   logic [7:0]   rcon_ff;
   logic [3:0]   step_ff;
   logic         busy_ff;
   logic [127:0] rk_ff [1:NUM_ROUNDS];

   // round key produced this cycle
   assign cur_in = next_round_key(cur_ff, rcon_ff);

   // key registers and expansion sequencer; restarts on every key write
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         cur_ff      <= '0;
         rcon_ff     <= 8'h01;
         step_ff     <= 4'd1;
         busy_ff     <= 1'b1;
      end else if (csr_we) begin
         if (csr_index == IDX_KEY_HIGH) begin
            key_high_ff <= csr_wdata;
            cur_ff      <= {csr_wdata, key_low_ff};
         end else begin
            key_low_ff <= csr_wdata;
            cur_ff     <= {key_high_ff, csr_wdata};
         end
         rcon_ff <= 8'h01;
         step_ff <= 4'd1;
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         cur_ff  <= cur_in;
         rcon_ff <= xtime(rcon_ff);
         step_ff <= step_ff + 4'd1;
         if (step_ff == LAST_STEP) busy_ff <= 1'b0;
      end
   end

   // round key storage
   always_ff @(posedge clock) begin
      if (busy_ff && !csr_we) rk_ff[step_ff] <= cur_in;
   end

   always_comb begin
      round_key[0] = {key_high_ff, key_low_ff};
      for (int i = 1; i <= NUM_ROUNDS; i++) round_key[i] = rk_ff[i];
   end

   assign status.busy = busy_ff;

endmodule

`default_nettype wire

@@ src/aescbc_dec_pipe.sv @@
`default_nettype none

module aescbc_dec_pipe
   import aescbc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,
   input  wire logic           in_valid,
   input  stage_type           in_stage,
   input  round_keys_type      round_key,
   output logic                out_valid,
   output stage_type           out_stage
);

   localparam int DEPTH = NUM_ROUNDS;

   stage_type stage_ff [DEPTH];
   logic      valid_ff [DEPTH];
   stage_type stage_in [DEPTH];

   // stage k applies decryption round NUM_ROUNDS-k to stage k-1
   always_comb begin
      stage_in[0] = in_stage;
      for (int k = 1; k < DEPTH; k++) begin
         stage_in[k]       = stage_ff[k - 1];
         stage_in[k].state = inv_mix(inv_shift_sub(stage_ff[k - 1].state)
                                     ^ round_key[NUM_ROUNDS - k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) valid_ff[k] <= valid_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DEPTH; k++) stage_ff[k] <= stage_in[k];
      end
   end

   // final round plus the CBC chaining xor
   always_comb begin
      out_valid       = valid_ff[DEPTH - 1];
      out_stage       = stage_ff[DEPTH - 1];
      out_stage.state = inv_shift_sub(stage_ff[DEPTH - 1].state) ^ round_key[0]
                        ^ stage_ff[DEPTH - 1].chain;
   end

endmodule

`default_nettype wire

@@ src/aes_cbc_decrypt_pad_check.sv @@
`default_nettype none
// AES-128 CBC decryption with PKCS#7 padding check.
// req_chan carries one 128-bit block per transfer plus is_iv and
// end_of_message; rsp_chan returns one plaintext block per ciphertext block.
// The IV transfer of a message returns nothing, unless it also ends the
// message, which returns an all-zero block flagged final with bad padding.
// The key is written through csr_we/csr_index/csr_wdata (index 0 = key_high,
// index 1 = key_low). Each key write starts a key expansion during
// which req_chan.ready is low; reset runs the same expansion for the zero key.
// A request passes the input register, nine round stages and the output
// register with round 0 and the padding check before it appears on rsp_chan.
// Throughput: one block per cycle while the receiver does not stall and no
// key expansion runs, set by the unrolled 10-stage round pipeline.
// When the receiver stalls, the whole pipeline holds and req_chan.ready
// drops until the waiting result is taken.
// Reset clears the key, the chaining state (awaiting IV) and all valid bits.

module aes_cbc_decrypt_pad_check
   import aescbc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   aescbc_req_if.sink       req_chan,
   aescbc_rsp_if.source     rsp_chan,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_wdata
);

   round_keys_type round_key;
   key_status_type key_status;

   logic [127:0] chain_ff;
   logic         have_iv_ff;
   logic         advance;
   logic         req_xfer;
   logic         take_iv;
   logic         pipe_in_valid;
   stage_type    pipe_in;
   logic         pipe_out_valid;
   stage_type    pipe_out;
   logic         pad_ok;

   logic         rsp_valid_ff;
   logic [127:0] plain_ff;
   logic         final_ff;
   logic         pad_valid_ff;

   aescbc_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .round_key (round_key),
      .status    (key_status)
   );

   // handshake
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance && !key_status.busy;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // a block seen while awaiting an IV is the IV
   assign take_iv       = req_chan.is_iv || !have_iv_ff;
   assign pipe_in_valid = req_xfer && (!take_iv || req_chan.end_of_message);

   always_comb begin
      pipe_in.state = {req_chan.block_high, req_chan.block_low} ^ round_key[NUM_ROUNDS];
      pipe_in.chain = chain_ff;
      pipe_in.last  = req_chan.end_of_message;
      pipe_in.empty = take_iv;
   end

   // chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= '0;
         have_iv_ff <= 1'b0;
      end else if (req_xfer) begin
         chain_ff   <= {req_chan.block_high, req_chan.block_low};
         have_iv_ff <= !req_chan.end_of_message;
      end
   end

   aescbc_dec_pipe u_dec_pipe (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pipe_in_valid),
      .in_stage  (pipe_in),
      .round_key (round_key),
      .out_valid (pipe_out_valid),
      .out_stage (pipe_out)
   );

   // PKCS#7 check: last byte n in 1..16 and the last n bytes equal n
   always_comb begin
      logic [7:0] n;
      n      = pipe_out.state[7:0];
      pad_ok = (n >= 8'd1) && (n <= 8'(BLOCK_BYTES));
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if ((8'(i) < n) && (pipe_out.state[8 * i +: 8] != n)) pad_ok = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= pipe_out_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         plain_ff     <= pipe_out.empty ? '0 : pipe_out.state;
         final_ff     <= pipe_out.last;
         pad_valid_ff <= pipe_out.last && !pipe_out.empty && pad_ok;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.plain_high    = plain_ff[127:64];
   assign rsp_chan.plain_low     = plain_ff[63:0];
   assign rsp_chan.final_block   = final_ff;
   assign rsp_chan.padding_valid = pad_valid_ff;

endmodule

`default_nettype wire

@@ src/aescbc_checker.sv @@
`default_nettype none

module aescbc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_plain_high,
   input wire logic [63:0] rsp_plain_low,
   input wire logic        rsp_final_block,
   input wire logic        rsp_padding_valid
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_plain_high)
         && $stable(rsp_plain_low) && $stable(rsp_final_block))
      else $error("result changed while stalled");

   // good padding only on a final block
   a_pad_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_padding_valid |-> rsp_final_block)
      else $error("padding_valid without final_block");

   // nothing leaves right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

   // the front end stops while the result stalls
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

endmodule

bind aes_cbc_decrypt_pad_check aescbc_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_plain_high    (rsp_chan.plain_high),
   .rsp_plain_low     (rsp_chan.plain_low),
   .rsp_final_block   (rsp_chan.final_block),
   .rsp_padding_valid (rsp_chan.padding_valid)
);

`default_nettype wire
